### src/spq_pkg.sv
package spq_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int PROJ_Q_W      = 35;
    localparam int SQ_W          = 64;
    localparam int SQ_STEPS      = 32;

    localparam logic [31:0]        FOCAL_RST   = 32'd32768000;
    localparam logic signed [31:0] CENTER_RST  = 32'sd0;
    localparam logic signed [31:0] NEAR_RST    = 32'sd655;
    localparam logic [15:0]        MIN_LEN_RST = 16'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_LENGTH = 3'd0,
        CFG_CENTER_X     = 3'd1,
        CFG_CENTER_Y     = 3'd2,
        CFG_NEAR_PLANE   = 3'd3,
        CFG_MIN_LENGTH   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic [15:0]        line_width;
    } in_t;

    typedef struct packed {
        logic               quad_valid;
        logic signed [31:0] p0_x;
        logic signed [31:0] p0_y;
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic signed [31:0] p3_x;
        logic signed [31:0] p3_y;
    } out_t;

    typedef struct packed {
        logic        zbad_a;
        logic        zbad_b;
        logic [3:0]  ovf;
        logic [3:0]  neg;
        logic [15:0] width;
    } proj_sb_t;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               dx_neg;
        logic               dy_nonneg;
        logic               ok;
    } norm_sb_t;

endpackage

### src/spq_div_cell.sv
module spq_div_cell #(
    parameter int LANES = 1,
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int Q_W   = 35,
    parameter int BIT   = 0,
    parameter int SB_W  = 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_vld,
    output logic                             in_rdy,
    input  logic [LANES-1:0][NUM_W-1:0]      in_rem,
    input  logic [LANES-1:0][DEN_W-1:0]      in_den,
    input  logic [LANES-1:0][Q_W-1:0]        in_quo,
    input  logic [SB_W-1:0]                  in_sb,
    output logic                             out_vld,
    input  logic                             out_rdy,
    output logic [LANES-1:0][NUM_W-1:0]      out_rem,
    output logic [LANES-1:0][DEN_W-1:0]      out_den,
    output logic [LANES-1:0][Q_W-1:0]        out_quo,
    output logic [SB_W-1:0]                  out_sb
);

    localparam int CMP_W = (NUM_W > DEN_W + BIT) ? NUM_W + 1 : DEN_W + BIT + 1;

    logic                        vld_reg;
    logic [LANES-1:0][NUM_W-1:0] rem_reg, rem_next;
    logic [LANES-1:0][DEN_W-1:0] den_reg;
    logic [LANES-1:0][Q_W-1:0]   quo_reg, quo_next;
    logic [SB_W-1:0]             sb_reg;

    genvar gl;
    generate
        for (gl = 0; gl < LANES; gl++) begin : g_lane
            logic [CMP_W-1:0] rem_ext;
            logic [CMP_W-1:0] den_sh;
            logic [CMP_W-1:0] diff;
            assign rem_ext = CMP_W'(in_rem[gl]);
            assign den_sh  = CMP_W'(in_den[gl]) << BIT;
            assign diff    = rem_ext - den_sh;
            always_comb begin
                if (rem_ext >= den_sh) begin
                    rem_next[gl] = diff[NUM_W-1:0];
                    quo_next[gl] = in_quo[gl] | (Q_W'(1) << BIT);
                end else begin
                    rem_next[gl] = in_rem[gl];
                    quo_next[gl] = in_quo[gl];
                end
            end
        end
    endgenerate

    assign in_rdy = !vld_reg || out_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_rdy) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_rdy) begin
            rem_reg <= rem_next;
            den_reg <= in_den;
            quo_reg <= quo_next;
            sb_reg  <= in_sb;
        end
    end

    assign out_vld = vld_reg;
    assign out_rem = rem_reg;
    assign out_den = den_reg;
    assign out_quo = quo_reg;
    assign out_sb  = sb_reg;

endmodule

### src/spq_sqrt_cell.sv
module spq_sqrt_cell import spq_pkg::*; #(
    parameter int STEP = 0,
    parameter int SB_W = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_vld,
    output logic            in_rdy,
    input  logic [SQ_W-1:0] in_v,
    input  logic [SQ_W-1:0] in_res,
    input  logic [SB_W-1:0] in_sb,
    output logic            out_vld,
    input  logic            out_rdy,
    output logic [SQ_W-1:0] out_v,
    output logic [SQ_W-1:0] out_res,
    output logic [SB_W-1:0] out_sb
);

    localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

    logic            vld_reg;
    logic [SQ_W-1:0] v_reg, v_next;
    logic [SQ_W-1:0] res_reg, res_next;
    logic [SB_W-1:0] sb_reg;
    logic [SQ_W-1:0] trial;

    assign trial = in_res + BIT_VAL;

    always_comb begin
        if (in_v >= trial) begin
            v_next   = in_v - trial;
            res_next = (in_res >> 1) + BIT_VAL;
        end else begin
            v_next   = in_v;
            res_next = in_res >> 1;
        end
    end

    assign in_rdy = !vld_reg || out_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_rdy) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_rdy) begin
            v_reg   <= v_next;
            res_reg <= res_next;
            sb_reg  <= in_sb;
        end
    end

    assign out_vld = vld_reg;
    assign out_v   = v_reg;
    assign out_res = res_reg;
    assign out_sb  = sb_reg;

endmodule

### src/segment_project_to_screen_quad_core.sv
// Line segment to screen quad.
// Input channel s_valid/s_ready/s_data carries one segment per transfer: both
// view-space endpoints and the line width. Output channel m_valid/m_ready/m_data
// carries one result per segment, in order: the four quad corners and
// quad_valid; a rejected segment returns quad_valid 0 and all corners 0.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata, one register
// per cycle; unknown indexes are dropped. The user must write it only while no
// segment is in flight; the block does not enforce this. Throughput is one
// segment per cycle while m_ready is high. FRAC_BITS defaults to 16 (Q16.16).
// Cell chains: a 35-cell divider for the projections, a 32-cell square-root
// chain for the segment length, a (FRAC_BITS + 7)-cell divider for the normal.
// Every stage has its own valid bit and moves when the stage after it is empty
// or moving, so a stalled receiver fills the bubbles first and s_ready drops
// only when every stage holds a segment. Reset empties the pipeline and loads
// the register defaults (focal length 500.0, near plane about 0.01).
module segment_project_to_screen_quad_core import spq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    localparam int HW_W  = FRAC_BITS + 7;
    localparam int PN_W  = 32 + HW_W;
    localparam int PSB_W = $bits(proj_sb_t);
    localparam int NSB_W = $bits(norm_sb_t);

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [PN_W-1:0]    pnx;
        logic [PN_W-1:0]    pny;
        logic               halved;
        logic               dx_neg;
        logic               dy_nonneg;
        logic               ok;
    } sq_sb_t;

    localparam int QSB_W = $bits(sq_sb_t);

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // configuration
    logic [31:0]        focal_reg;
    logic signed [31:0] cx_reg, cy_reg, near_reg;
    logic [15:0]        min_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg   <= FOCAL_RST;
            cx_reg      <= CENTER_RST;
            cy_reg      <= CENTER_RST;
            near_reg    <= NEAR_RST;
            min_len_reg <= MIN_LEN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_FOCAL_LENGTH: focal_reg   <= cfg_wdata;
                CFG_CENTER_X:     cx_reg      <= cfg_wdata;
                CFG_CENTER_Y:     cy_reg      <= cfg_wdata;
                CFG_NEAR_PLANE:   near_reg    <= cfg_wdata;
                CFG_MIN_LENGTH:   min_len_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // stage 1: magnitudes, depth rejection, quotient signs
    logic                 s1_vld_reg, s2_rdy;
    logic [3:0][31:0]     s1_mag_reg;
    logic [31:0]          s1_za_reg, s1_zb_reg;
    proj_sb_t             s1_sb_reg, s1_sb_next;

    always_comb begin
        s1_sb_next.zbad_a = (s_data.a_z <= near_reg) || (s_data.a_z == 32'sd0);
        s1_sb_next.zbad_b = (s_data.b_z <= near_reg) || (s_data.b_z == 32'sd0);
        s1_sb_next.ovf    = 4'b0;
        s1_sb_next.neg[0] = s_data.a_x[31] ^ s_data.a_z[31];
        s1_sb_next.neg[1] = !(s_data.a_y[31] ^ s_data.a_z[31]);
        s1_sb_next.neg[2] = s_data.b_x[31] ^ s_data.b_z[31];
        s1_sb_next.neg[3] = !(s_data.b_y[31] ^ s_data.b_z[31]);
        s1_sb_next.width  = s_data.line_width;
    end

    assign s_ready = !s1_vld_reg || s2_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s_ready) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_mag_reg[0] <= mag32(s_data.a_x);
            s1_mag_reg[1] <= mag32(s_data.a_y);
            s1_mag_reg[2] <= mag32(s_data.b_x);
            s1_mag_reg[3] <= mag32(s_data.b_y);
            s1_za_reg     <= mag32(s_data.a_z);
            s1_zb_reg     <= mag32(s_data.b_z);
            s1_sb_reg     <= s1_sb_next;
        end
    end

    // stage 2: focal products
    logic             s2_vld_reg;
    logic [3:0][63:0] s2_p_reg;
    logic [31:0]      s2_za_reg, s2_zb_reg;
    proj_sb_t         s2_sb_reg;

    logic [PROJ_Q_W:0]            p_vld, p_rdy;
    logic [3:0][63:0]             p_rem [PROJ_Q_W+1];
    logic [3:0][31:0]             p_den [PROJ_Q_W+1];
    logic [3:0][PROJ_Q_W-1:0]     p_quo [PROJ_Q_W+1];
    logic [PSB_W-1:0]             p_sb  [PROJ_Q_W+1];
    proj_sb_t                     p_sb_in;

    assign s2_rdy = !s2_vld_reg || p_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (s2_rdy) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_rdy) begin
            for (int i = 0; i < 4; i++) begin
                s2_p_reg[i] <= focal_reg * s1_mag_reg[i];
            end
            s2_za_reg <= s1_za_reg;
            s2_zb_reg <= s1_zb_reg;
            s2_sb_reg <= s1_sb_reg;
        end
    end

    // projection divider chain
    always_comb begin
        p_sb_in = s2_sb_reg;
        p_sb_in.ovf[0] = 32'(s2_p_reg[0][63:PROJ_Q_W]) >= s2_za_reg;
        p_sb_in.ovf[1] = 32'(s2_p_reg[1][63:PROJ_Q_W]) >= s2_za_reg;
        p_sb_in.ovf[2] = 32'(s2_p_reg[2][63:PROJ_Q_W]) >= s2_zb_reg;
        p_sb_in.ovf[3] = 32'(s2_p_reg[3][63:PROJ_Q_W]) >= s2_zb_reg;
    end

    assign p_vld[0] = s2_vld_reg;
    assign p_rem[0] = s2_p_reg;
    assign p_den[0] = {s2_zb_reg, s2_zb_reg, s2_za_reg, s2_za_reg};
    assign p_quo[0] = '0;
    assign p_sb[0]  = p_sb_in;

    genvar gk;
    generate
        for (gk = 0; gk < PROJ_Q_W; gk++) begin : g_proj
            spq_div_cell #(
                .LANES(4), .NUM_W(64), .DEN_W(32), .Q_W(PROJ_Q_W),
                .BIT(PROJ_Q_W - 1 - gk), .SB_W(PSB_W)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .in_vld(p_vld[gk]), .in_rdy(p_rdy[gk]),
                .in_rem(p_rem[gk]), .in_den(p_den[gk]),
                .in_quo(p_quo[gk]), .in_sb(p_sb[gk]),
                .out_vld(p_vld[gk+1]), .out_rdy(p_rdy[gk+1]),
                .out_rem(p_rem[gk+1]), .out_den(p_den[gk+1]),
                .out_quo(p_quo[gk+1]), .out_sb(p_sb[gk+1])
            );
        end
    endgenerate

    // stage 4: center offset and range check
    logic                     s4_vld_reg, s4_rdy, s5_rdy;
    logic [3:0][31:0]         s4_pt_reg, s4_pt_next;
    logic                     s4_ok_reg, s4_ok_next;
    logic [15:0]              s4_w_reg;
    proj_sb_t                 p_sb_out;
    logic [3:0]               lane_ok;

    assign p_sb_out = p_sb[PROJ_Q_W];

    always_comb begin
        logic signed [35:0] c36;
        logic signed [35:0] q36;
        logic signed [35:0] r36;
        for (int i = 0; i < 4; i++) begin
            c36 = (i == 0 || i == 2) ? 36'(cx_reg) : 36'(cy_reg);
            q36 = signed'({1'b0, p_quo[PROJ_Q_W][i]});
            r36 = p_sb_out.neg[i] ? (c36 - q36) : (c36 + q36);
            s4_pt_next[i] = r36[31:0];
            lane_ok[i] = (p_quo[PROJ_Q_W][i] <= (PROJ_Q_W'(1) << (PROJ_Q_W - 1)))
                && ((r36[35:31] == 5'b00000) || (r36[35:31] == 5'b11111));
        end
        s4_ok_next = (&lane_ok) && !(|p_sb_out.ovf) && !p_sb_out.zbad_a && !p_sb_out.zbad_b;
    end

    assign s4_rdy = !s4_vld_reg || s5_rdy;
    assign p_rdy[PROJ_Q_W] = s4_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (s4_rdy) begin
            s4_vld_reg <= p_vld[PROJ_Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_rdy) begin
            s4_pt_reg <= s4_pt_next;
            s4_ok_reg <= s4_ok_next;
            s4_w_reg  <= p_sb_out.width;
        end
    end

    // stage 5: span, magnitudes, half width
    logic                     s5_vld_reg, s6_rdy;
    logic [3:0][31:0]         s5_pt_reg;
    logic [31:0]              s5_dxm_reg, s5_dym_reg;
    logic                     s5_halved_reg, s5_dx_neg_reg, s5_dy_nonneg_reg, s5_ok_reg;
    logic [HW_W-1:0]          s5_hw_reg;
    logic signed [32:0]       dx33, dy33;
    logic [32:0]              dxm33, dym33;
    logic                     halve;
    logic [16+FRAC_BITS-1:0]  wsh;

    assign dx33  = 33'(signed'(s4_pt_reg[2])) - 33'(signed'(s4_pt_reg[0]));
    assign dy33  = 33'(signed'(s4_pt_reg[3])) - 33'(signed'(s4_pt_reg[1]));
    assign dxm33 = dx33[32] ? (~dx33 + 33'd1) : dx33;
    assign dym33 = dy33[32] ? (~dy33 + 33'd1) : dy33;
    assign halve = (|dxm33[32:31]) || (|dym33[32:31]);
    assign wsh   = {s4_w_reg, {FRAC_BITS{1'b0}}};

    assign s5_rdy = !s5_vld_reg || s6_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (s5_rdy) begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_rdy) begin
            s5_pt_reg        <= s4_pt_reg;
            s5_dxm_reg       <= halve ? dxm33[32:1] : dxm33[31:0];
            s5_dym_reg       <= halve ? dym33[32:1] : dym33[31:0];
            s5_halved_reg    <= halve;
            s5_dx_neg_reg    <= dx33[32];
            s5_dy_nonneg_reg <= !dy33[32];
            s5_ok_reg        <= s4_ok_reg && (s4_w_reg != 16'd0);
            s5_hw_reg        <= wsh[16+FRAC_BITS-1:9];
        end
    end

    // stage 6: squares and normal numerators
    logic             s6_vld_reg, s7_rdy;
    logic [63:0]      s6_sqx_reg, s6_sqy_reg;
    logic [PN_W-1:0]  s6_pnx_reg, s6_pny_reg;
    logic [3:0][31:0] s6_pt_reg;
    logic             s6_halved_reg, s6_dx_neg_reg, s6_dy_nonneg_reg, s6_ok_reg;

    assign s6_rdy = !s6_vld_reg || s7_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_vld_reg <= 1'b0;
        end else if (s6_rdy) begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s6_rdy) begin
            s6_sqx_reg       <= s5_dxm_reg * s5_dxm_reg;
            s6_sqy_reg       <= s5_dym_reg * s5_dym_reg;
            s6_pnx_reg       <= PN_W'(s5_dym_reg) * PN_W'(s5_hw_reg);
            s6_pny_reg       <= PN_W'(s5_dxm_reg) * PN_W'(s5_hw_reg);
            s6_pt_reg        <= s5_pt_reg;
            s6_halved_reg    <= s5_halved_reg;
            s6_dx_neg_reg    <= s5_dx_neg_reg;
            s6_dy_nonneg_reg <= s5_dy_nonneg_reg;
            s6_ok_reg        <= s5_ok_reg;
        end
    end

    // stage 7: sum of squares
    logic        s7_vld_reg;
    logic [63:0] s7_sum_reg;
    sq_sb_t      s7_sb_reg;

    logic [SQ_STEPS:0]  q_vld, q_rdy;
    logic [SQ_W-1:0]    q_v   [SQ_STEPS+1];
    logic [SQ_W-1:0]    q_res [SQ_STEPS+1];
    logic [QSB_W-1:0]   q_sb  [SQ_STEPS+1];

    assign s7_rdy = !s7_vld_reg || q_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_vld_reg <= 1'b0;
        end else if (s7_rdy) begin
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s7_rdy) begin
            s7_sum_reg          <= s6_sqx_reg + s6_sqy_reg;
            s7_sb_reg.ax        <= s6_pt_reg[0];
            s7_sb_reg.ay        <= s6_pt_reg[1];
            s7_sb_reg.bx        <= s6_pt_reg[2];
            s7_sb_reg.by        <= s6_pt_reg[3];
            s7_sb_reg.pnx       <= s6_pnx_reg;
            s7_sb_reg.pny       <= s6_pny_reg;
            s7_sb_reg.halved    <= s6_halved_reg;
            s7_sb_reg.dx_neg    <= s6_dx_neg_reg;
            s7_sb_reg.dy_nonneg <= s6_dy_nonneg_reg;
            s7_sb_reg.ok        <= s6_ok_reg;
        end
    end

    // square-root chain
    assign q_vld[0] = s7_vld_reg;
    assign q_v[0]   = s7_sum_reg;
    assign q_res[0] = '0;
    assign q_sb[0]  = s7_sb_reg;

    generate
        for (gk = 0; gk < SQ_STEPS; gk++) begin : g_sqrt
            spq_sqrt_cell #(.STEP(gk), .SB_W(QSB_W)) u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .in_vld(q_vld[gk]), .in_rdy(q_rdy[gk]),
                .in_v(q_v[gk]), .in_res(q_res[gk]), .in_sb(q_sb[gk]),
                .out_vld(q_vld[gk+1]), .out_rdy(q_rdy[gk+1]),
                .out_v(q_v[gk+1]), .out_res(q_res[gk+1]), .out_sb(q_sb[gk+1])
            );
        end
    endgenerate

    // normal divider chain
    sq_sb_t                   q_sb_out;
    logic [31:0]              len;
    norm_sb_t                 n_sb_in;
    logic [HW_W:0]            n_vld, n_rdy;
    logic [1:0][PN_W-1:0]     n_rem [HW_W+1];
    logic [1:0][31:0]         n_den [HW_W+1];
    logic [1:0][HW_W-1:0]     n_quo [HW_W+1];
    logic [NSB_W-1:0]         n_sb  [HW_W+1];

    assign q_sb_out = q_sb[SQ_STEPS];
    assign len      = q_res[SQ_STEPS][31:0];

    always_comb begin
        n_sb_in.ax        = q_sb_out.ax;
        n_sb_in.ay        = q_sb_out.ay;
        n_sb_in.bx        = q_sb_out.bx;
        n_sb_in.by        = q_sb_out.by;
        n_sb_in.dx_neg    = q_sb_out.dx_neg;
        n_sb_in.dy_nonneg = q_sb_out.dy_nonneg;
        n_sb_in.ok        = q_sb_out.ok && (len != 32'd0)
            && (q_sb_out.halved || (len >= 32'(min_len_reg)));
    end

    assign n_vld[0]     = q_vld[SQ_STEPS];
    assign q_rdy[SQ_STEPS] = n_rdy[0];
    assign n_rem[0]     = {q_sb_out.pny, q_sb_out.pnx};
    assign n_den[0]     = {len, len};
    assign n_quo[0]     = '0;
    assign n_sb[0]      = n_sb_in;

    generate
        for (gk = 0; gk < HW_W; gk++) begin : g_norm
            spq_div_cell #(
                .LANES(2), .NUM_W(PN_W), .DEN_W(32), .Q_W(HW_W),
                .BIT(HW_W - 1 - gk), .SB_W(NSB_W)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .in_vld(n_vld[gk]), .in_rdy(n_rdy[gk]),
                .in_rem(n_rem[gk]), .in_den(n_den[gk]),
                .in_quo(n_quo[gk]), .in_sb(n_sb[gk]),
                .out_vld(n_vld[gk+1]), .out_rdy(n_rdy[gk+1]),
                .out_rem(n_rem[gk+1]), .out_den(n_den[gk+1]),
                .out_quo(n_quo[gk+1]), .out_sb(n_sb[gk+1])
            );
        end
    endgenerate

    // output stage: corners
    logic               m_vld_reg, out_rdy;
    out_t               m_data_reg, m_data_next;
    norm_sb_t           n_sb_out;
    logic signed [HW_W:0] nx_s, ny_s;
    logic signed [33:0] nx34, ny34;
    logic signed [33:0] c34 [8];
    logic [7:0]         fit;

    assign n_sb_out = n_sb[HW_W];

    always_comb begin
        nx_s = signed'({1'b0, n_quo[HW_W][0]});
        ny_s = signed'({1'b0, n_quo[HW_W][1]});
        if (n_sb_out.dy_nonneg) begin
            nx_s = -nx_s;
        end
        if (n_sb_out.dx_neg) begin
            ny_s = -ny_s;
        end
        nx34 = 34'(nx_s);
        ny34 = 34'(ny_s);
        c34[0] = 34'(n_sb_out.ax) + nx34;
        c34[1] = 34'(n_sb_out.ay) + ny34;
        c34[2] = 34'(n_sb_out.bx) + nx34;
        c34[3] = 34'(n_sb_out.by) + ny34;
        c34[4] = 34'(n_sb_out.bx) - nx34;
        c34[5] = 34'(n_sb_out.by) - ny34;
        c34[6] = 34'(n_sb_out.ax) - nx34;
        c34[7] = 34'(n_sb_out.ay) - ny34;
        for (int i = 0; i < 8; i++) begin
            fit[i] = (c34[i][33:31] == 3'b000) || (c34[i][33:31] == 3'b111);
        end
        m_data_next = '0;
        if (n_sb_out.ok && (&fit)) begin
            m_data_next.quad_valid = 1'b1;
            m_data_next.p0_x = c34[0][31:0];
            m_data_next.p0_y = c34[1][31:0];
            m_data_next.p1_x = c34[2][31:0];
            m_data_next.p1_y = c34[3][31:0];
            m_data_next.p2_x = c34[4][31:0];
            m_data_next.p2_y = c34[5][31:0];
            m_data_next.p3_x = c34[6][31:0];
            m_data_next.p3_y = c34[7][31:0];
        end
    end

    assign out_rdy      = !m_vld_reg || m_ready;
    assign n_rdy[HW_W]  = out_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (out_rdy) begin
            m_vld_reg <= n_vld[HW_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

endmodule

### verif/tb_segment_project_to_screen_quad_core.sv
`timescale 1ns / 100ps

module tb_segment_project_to_screen_quad_core;
    import spq_pkg::*;

    localparam int FB      = 16;
    localparam int LATENCY = 81 + FB;

    class quad_scoreboard;
        logic [31:0]        focal;
        logic signed [31:0] cen_x;
        logic signed [31:0] cen_y;
        logic signed [31:0] near_z;
        logic [15:0]        min_len;
        out_t               pending_quads[$];
        int                 errors;

        function new();
            focal   = FOCAL_RST;
            cen_x   = CENTER_RST;
            cen_y   = CENTER_RST;
            near_z  = NEAR_RST;
            min_len = MIN_LEN_RST;
            errors  = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_FOCAL_LENGTH: focal   = val;
                CFG_CENTER_X:     cen_x   = val;
                CFG_CENTER_Y:     cen_y   = val;
                CFG_NEAR_PLANE:   near_z  = val;
                CFG_MIN_LENGTH:   min_len = val[15:0];
                default: ;
            endcase
        endfunction

        function automatic logic [63:0] mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function automatic logic [63:0] root(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic bit project(longint v, longint z, longint c, bit flip,
                                       output longint res);
            logic [63:0] p;
            logic [63:0] q;
            bit          s;
            longint      r;
            res = 0;
            if (z <= longint'(near_z) || z == 0) return 0;
            p = {32'd0, focal} * mag(v);
            q = p / mag(z);
            if (q > (64'd1 << 34)) return 0;
            s = ((v < 0) != (z < 0)) != flip;
            r = c + (s ? -longint'(q) : longint'(q));
            if (r > 64'sd2147483647 || r < -64'sd2147483648) return 0;
            res = r;
            return 1;
        endfunction

        function automatic out_t quad_of(in_t seg);
            out_t        o;
            longint      ax, ay, bx, by, dx, dy, nx, ny;
            longint      c[8];
            logic [63:0] dxm, dym, len, hw;
            bit          ok;
            o  = '0;
            ok = project(seg.a_x, seg.a_z, cen_x, 0, ax);
            ok = ok && project(seg.a_y, seg.a_z, cen_y, 1, ay);
            ok = ok && project(seg.b_x, seg.b_z, cen_x, 0, bx);
            ok = ok && project(seg.b_y, seg.b_z, cen_y, 1, by);
            if (!ok || seg.line_width == 0) return o;
            dx  = bx - ax;
            dy  = by - ay;
            dxm = mag(dx);
            dym = mag(dy);
            if (dxm >= (64'd1 << 31) || dym >= (64'd1 << 31)) begin
                dxm = dxm >> 1;
                dym = dym >> 1;
                len = root(dxm * dxm + dym * dym);
            end else begin
                len = root(dxm * dxm + dym * dym);
                if (len < min_len) return o;
            end
            if (len == 0) return o;
            hw = ({48'd0, seg.line_width} << FB) >> 9;
            nx = (dym * hw) / len;
            ny = (dxm * hw) / len;
            if (dy >= 0) nx = -nx;
            if (dx < 0) ny = -ny;
            c[0] = ax + nx; c[1] = ay + ny;
            c[2] = bx + nx; c[3] = by + ny;
            c[4] = bx - nx; c[5] = by - ny;
            c[6] = ax - nx; c[7] = ay - ny;
            foreach (c[i])
                if (c[i] > 64'sd2147483647 || c[i] < -64'sd2147483648) return o;
            o.quad_valid = 1'b1;
            o.p0_x = 32'(c[0]); o.p0_y = 32'(c[1]);
            o.p1_x = 32'(c[2]); o.p1_y = 32'(c[3]);
            o.p2_x = 32'(c[4]); o.p2_y = 32'(c[5]);
            o.p3_x = 32'(c[6]); o.p3_y = 32'(c[7]);
            return o;
        endfunction

        function void note_segment(in_t seg);
            pending_quads.push_back(quad_of(seg));
        endfunction

        function void check_quad(out_t got);
            out_t exp_q;
            if (pending_quads.size() == 0) begin
                $display("%0t: unexpected transfer, actual %h", $time, got);
                errors++;
                return;
            end
            exp_q = pending_quads.pop_front();
            if (got.quad_valid !== exp_q.quad_valid) begin
                $display("%0t: quad_valid expected %0d actual %0d", $time,
                         exp_q.quad_valid, got.quad_valid);
                errors++;
            end
            if (got.p0_x !== exp_q.p0_x || got.p0_y !== exp_q.p0_y) begin
                $display("%0t: p0 expected %h %h actual %h %h", $time,
                         exp_q.p0_x, exp_q.p0_y, got.p0_x, got.p0_y);
                errors++;
            end
            if (got.p1_x !== exp_q.p1_x || got.p1_y !== exp_q.p1_y) begin
                $display("%0t: p1 expected %h %h actual %h %h", $time,
                         exp_q.p1_x, exp_q.p1_y, got.p1_x, got.p1_y);
                errors++;
            end
            if (got.p2_x !== exp_q.p2_x || got.p2_y !== exp_q.p2_y) begin
                $display("%0t: p2 expected %h %h actual %h %h", $time,
                         exp_q.p2_x, exp_q.p2_y, got.p2_x, got.p2_y);
                errors++;
            end
            if (got.p3_x !== exp_q.p3_x || got.p3_y !== exp_q.p3_y) begin
                $display("%0t: p3 expected %h %h actual %h %h", $time,
                         exp_q.p3_x, exp_q.p3_y, got.p3_x, got.p3_y);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;

    quad_scoreboard sb;
    bit             src_done;
    bit             sink_hold;

    segment_project_to_screen_quad_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    int src_gap_max;
    int sink_gap_max;

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= CFG_MIN_LENGTH) sb.set_reg(cfg_idx_t'(idx), val);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_quads.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic send_segment(in_t seg);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= seg;
        do @(posedge aclk); while (!s_ready);
        sb.note_segment(seg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_quad(m_data);
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = sink_hold ? 0 : $urandom_range(0, sink_gap_max);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rnd_depth();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 2000);
            default: return $urandom_range(1 << 15, 200 << 16);
        endcase
    endfunction

    function automatic in_t rnd_segment();
        in_t seg;
        seg.a_x = rnd_coord();
        seg.a_y = rnd_coord();
        seg.a_z = rnd_depth();
        seg.b_x = rnd_coord();
        seg.b_y = rnd_coord();
        seg.b_z = rnd_depth();
        case ($urandom_range(0, 9))
            0: seg.line_width = 16'd0;
            1: seg.line_width = 16'($urandom);
            default: seg.line_width = 16'($urandom_range(1, 16 << 8));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            seg.b_x = seg.a_x;
            seg.b_y = seg.a_y;
            seg.b_z = seg.a_z;
        end
        return seg;
    endfunction

    function automatic in_t mk(int ax, int ay, int az, int bx, int by, int bz,
                               int w);
        in_t seg;
        seg.a_x = ax; seg.a_y = ay; seg.a_z = az;
        seg.b_x = bx; seg.b_y = by; seg.b_z = bz;
        seg.line_width = 16'(w);
        return seg;
    endfunction

    initial begin
        in_t directed[$];
        sb          = new();
        src_done    = 0;
        sink_hold   = 0;
        src_gap_max = 13;
        sink_gap_max = 13;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed.push_back(mk(0, 0, 65536, 65536, 65536, 65536, 256));
        directed.push_back(mk(-65536, 65536, 131072, 65536, -65536, 131072, 16'hffff));
        directed.push_back(mk(0, 0, 655, 65536, 0, 65536, 256));
        directed.push_back(mk(0, 0, 656, 65536, 0, 65536, 256));
        directed.push_back(mk(0, 0, 65536, 65536, 0, 65536, 0));
        directed.push_back(mk(0, 0, 65536, 0, 0, 65536, 256));
        directed.push_back(mk(0, 0, 65536, 0, 0, 65536 * 100, 256));
        directed.push_back(mk(32'h7fffffff, 0, 65536, 0, 0, 65536, 256));
        directed.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
        directed.push_back(mk(0, 0, 32'h80000000, 0, 0, 65536, 256));
        directed.push_back(mk(1, 0, 65536 * 1000, 0, 0, 65536 * 1000, 256));
        foreach (directed[i]) send_segment(directed[i]);
        drain();

        write_reg(CFG_NEAR_PLANE, 32'hffff0000);
        write_reg(CFG_MIN_LENGTH, 32'd0);
        write_reg(CFG_FOCAL_LENGTH, 32'hffffffff);
        write_reg(3'd7, 32'h12345678);
        send_segment(mk(65536, 0, 0, 0, 0, 65536, 256));
        send_segment(mk(-65536, 65536, -65536, 65536, 0, 65536, 256));
        send_segment(mk(0, 0, 65536, 0, 0, 65536, 256));
        send_segment(mk(65536 * 100, 0, 65536, -65536 * 100, 0, 65536, 256));
        drain();
        write_reg(CFG_CENTER_X, 32'h7fff0000);
        write_reg(CFG_CENTER_Y, 32'h80000000);
        write_reg(CFG_FOCAL_LENGTH, 32'd0);
        send_segment(mk(65536, 65536, 65536, 0, 0, 65536, 16'hffff));
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_FOCAL_LENGTH, FOCAL_RST);
                    write_reg(CFG_CENTER_X, 32'd320 << 16);
                    write_reg(CFG_CENTER_Y, 32'd240 << 16);
                    write_reg(CFG_NEAR_PLANE, NEAR_RST);
                    write_reg(CFG_MIN_LENGTH, 32'(MIN_LEN_RST));
                end
                1: begin
                    write_reg(CFG_MIN_LENGTH, 32'hffff);
                    src_gap_max = 0;
                    sink_gap_max = 0;
                end
                2: begin
                    write_reg(CFG_FOCAL_LENGTH, $urandom);
                    write_reg(CFG_CENTER_X, $urandom);
                    write_reg(CFG_CENTER_Y, $urandom);
                    src_gap_max = 13;
                    sink_gap_max = 13;
                end
                3: begin
                    write_reg(CFG_NEAR_PLANE, 32'h80000000);
                    write_reg(CFG_MIN_LENGTH, 32'd0);
                    src_gap_max = 0;
                end
                4: begin
                    write_reg(CFG_NEAR_PLANE, 32'h7fffffff);
                    src_gap_max = 13;
                    sink_gap_max = 0;
                end
                5: begin
                    write_reg(CFG_NEAR_PLANE, NEAR_RST);
                    write_reg(CFG_FOCAL_LENGTH, 32'd65536 * 800);
                    write_reg(CFG_CENTER_X, 32'h7fffffff);
                    write_reg(CFG_CENTER_Y, 32'h80000000);
                    sink_gap_max = 13;
                end
                6: begin
                    write_reg(CFG_CENTER_X, 32'd0);
                    write_reg(CFG_CENTER_Y, 32'd0);
                    write_reg(CFG_MIN_LENGTH, $urandom_range(0, 65535));
                    src_gap_max = 3;
                end
                default: begin
                    write_reg(CFG_FOCAL_LENGTH, FOCAL_RST);
                    write_reg(CFG_MIN_LENGTH, 32'(MIN_LEN_RST));
                    src_gap_max = 13;
                end
            endcase
            repeat (200) send_segment(rnd_segment());
            drain();
        end

        src_done = 1;
    end

    initial begin
        wait (src_done);
        if (sb.errors == 0 && sb.pending_quads.size() == 0) begin
            $display("segment_project_to_screen_quad_core verification clean");
        end else begin
            $display("segment_project_to_screen_quad_core verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("segment_project_to_screen_quad_core verification failed");
        $finish;
    end

endmodule
